/* src/hcl_pkg.sv */
// Package for the hysteresis comparator bank with truth-table output.
// Holds the channel payload types, queue entry, register image and codes.
// No dependencies.
package hcl_pkg;

    // Level ceiling for thresholds, hysteresis and the inverted limit
    localparam logic [6:0] LEVEL_MAX = 7'd100;

    // APB address width: three 64-bit registers at 8-byte spacing
    localparam int ADDR_W = 5;

    // Command codes
    localparam logic CMD_SAMPLE      = 1'b0;
    localparam logic CMD_TABLE_WRITE = 1'b1;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_HYSTERESIS = 2'd1;
    localparam logic [1:0] REG_INVERT     = 2'd2;

    typedef struct packed {
        logic       command;
        logic [7:0] sample_a;
        logic [7:0] sample_b;
        logic [7:0] sample_c;
        logic [7:0] sample_d;
        logic [7:0] sample_e;
        logic [7:0] sample_f;
        logic [7:0] sample_g;
        logic [7:0] sample_h;
        logic [7:0] table_index;
        logic [7:0] table_data;
    } in_t;

    typedef struct packed {
        logic [7:0] input_bits;
        logic [7:0] output_bits;
    } out_t;

    // Work handed from front to back: a table write or a table lookup
    typedef struct packed {
        logic       is_write;
        logic [7:0] addr;
        logic [7:0] data;
    } q_entry_t;

    // Register image seen by the comparators
    typedef struct packed {
        logic [63:0] threshold;
        logic [63:0] hysteresis;
        logic [7:0]  invert;
    } cfg_t;

endpackage

/* src/hcl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
module hcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/hcl_regs.sv */
// APB configuration registers: thresholds, hysteresis and invert mask.
// Depends on hcl_pkg.
module hcl_regs
    import hcl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [63:0] threshold_reg;
    logic [63:0] hysteresis_reg;
    logic [7:0]  invert_reg;
    logic [1:0]  index;
    logic        wr_en;

    assign pready = 1'b1;
    assign index  = paddr[4:3];
    assign wr_en  = psel && penable && pwrite && pready;

    // Take register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= 64'h3232_3232_3232_3232;
            hysteresis_reg <= 64'h0;
            invert_reg     <= 8'h0;
        end else if (wr_en) begin
            unique case (index)
                REG_THRESHOLD:  threshold_reg  <= pwdata;
                REG_HYSTERESIS: hysteresis_reg <= pwdata;
                REG_INVERT:     invert_reg     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (index)
            REG_THRESHOLD:  prdata = threshold_reg;
            REG_HYSTERESIS: prdata = hysteresis_reg;
            REG_INVERT:     prdata = {56'h0, invert_reg};
            default:        prdata = 64'h0;
        endcase
    end

    assign cfg = '{threshold: threshold_reg, hysteresis: hysteresis_reg,
                   invert: invert_reg};

endmodule

/* src/hcl_front.sv */
// Front end: accepts transactions, updates the trigger flags of the comparator
// bank and hands a table write or lookup to the queue. Depends on hcl_pkg.
module hcl_front
    import hcl_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_t      s_data,
    output logic     push_valid,
    input  logic     push_ready,
    output q_entry_t push_entry
);

    logic [7:0] flags_reg;
    logic [7:0] flags_next;
    logic [7:0] samples [8];
    logic       is_write;
    logic       accept;

    function automatic logic [6:0] clamp_level(input logic [7:0] v);
        return (v > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : v[6:0];
    endfunction

    assign samples[0] = s_data.sample_a;
    assign samples[1] = s_data.sample_b;
    assign samples[2] = s_data.sample_c;
    assign samples[3] = s_data.sample_d;
    assign samples[4] = s_data.sample_e;
    assign samples[5] = s_data.sample_f;
    assign samples[6] = s_data.sample_g;
    assign samples[7] = s_data.sample_h;

    // Evaluate every comparator; channel ch lands on bit 7-ch
    always_comb begin
        logic [6:0] th;
        logic [6:0] hy;
        logic [7:0] sum;
        logic [6:0] lim;
        logic       on;
        flags_next = 8'h0;
        for (int ch = 0; ch < 8; ch++) begin
            th  = clamp_level(cfg.threshold[8*ch +: 8]);
            hy  = clamp_level(cfg.hysteresis[8*ch +: 8]);
            sum = {1'b0, th} + {1'b0, hy};
            on  = flags_reg[7-ch];
            lim = 7'd0;
            if (ch < CHANNELS) begin
                if (!cfg.invert[ch]) begin
                    lim = (hy > th) ? 7'd0 : th - hy;
                    if (!on) begin
                        flags_next[7-ch] = samples[ch] >= {1'b0, th};
                    end else begin
                        flags_next[7-ch] = !(samples[ch] < {1'b0, lim});
                    end
                end else begin
                    lim = (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[6:0];
                    if (!on) begin
                        flags_next[7-ch] = samples[ch] <= {1'b0, th};
                    end else begin
                        flags_next[7-ch] = !(samples[ch] > {1'b0, lim});
                    end
                end
            end
        end
    end

    assign is_write   = s_data.command == CMD_TABLE_WRITE;
    assign s_ready    = push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = s_valid;
    assign push_entry = '{is_write: is_write,
                          addr: is_write ? s_data.table_index : flags_next,
                          data: s_data.table_data};

    // Advance the flags on each accepted sample set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= 8'h0;
        end else if (accept && !is_write) begin
            flags_reg <= flags_next;
        end
    end

endmodule

/* src/hcl_queue.sv */
// Short FIFO between front and back so each side can stall on its own.
// Depends on hcl_pkg.
module hcl_queue
    import hcl_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  q_entry_t in_entry,
    output logic     out_valid,
    input  logic     out_ready,
    output q_entry_t out_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    q_entry_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_entry = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Hold entries; advance pointers on push and pop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

/* src/hcl_back.sv */
// Back end: carries out table writes and lookups against the truth-table RAM
// and drives the result channel. Depends on hcl_pkg and hcl_ram.
module hcl_back
    import hcl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    output logic     q_ready,
    input  q_entry_t q_entry,
    output logic     m_valid,
    input  logic     m_ready,
    output out_t     m_data
);

    logic       out_valid_reg;
    logic [7:0] flags_reg;
    logic [7:0] rdata;
    logic       out_free;
    logic       ram_we;
    logic       ram_re;

    // A lookup needs the output slot; a write never does
    assign out_free = !out_valid_reg || m_ready;
    assign q_ready  = q_entry.is_write || out_free;
    assign ram_we   = q_valid && q_entry.is_write;
    assign ram_re   = q_valid && !q_entry.is_write && out_free;

    hcl_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_entry.addr),
        .wdata (q_entry.data),
        .re    (ram_re),
        .raddr (q_entry.addr),
        .rdata (rdata)
    );

    // Output slot: the RAM read register holds the table byte alongside it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ram_re) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            flags_reg <= q_entry.addr;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = '{input_bits: flags_reg, output_bits: rdata};

endmodule

/* src/hysteresis_comparator_lut_core.sv */
// Top level of the hysteresis comparator bank with truth-table output.
// Depends on hcl_pkg, hcl_regs, hcl_front, hcl_queue, hcl_back and hcl_ram.

// One transaction is accepted per clock while the queue has room, sample set or
// table write alike; the limit is the truth-table RAM, which serves one write or
// one lookup a cycle. The front evaluates all comparators in the cycle of
// acceptance and queues the work; a sample set's result reaches m_valid through
// the queue register and then the registered RAM read, later if the result
// channel stalls. Table writes give no result. A lookup of an entry that was
// never written returns an undefined byte. Configuration is written through
// the APB port with 64-bit data at byte addresses 0, 8 and 16; the user must
// write it only while the block is idle, and the block does not enforce this.
module hysteresis_comparator_lut_core
    import hcl_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data
);

    localparam logic [7:0] CHAN_MASK = 8'hFF << (8 - CHANNELS);

    cfg_t     cfg;
    logic     push_valid;
    logic     push_ready;
    q_entry_t push_entry;
    logic     q_valid;
    logic     q_ready;
    q_entry_t q_entry;

    hcl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hcl_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    hcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry)
    );

    hcl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A lookup leaves the queue only when the output slot is free
    a_lookup_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready && !q_entry.is_write |-> !m_valid || m_ready)
        else $error("lookup issued while result slot occupied");

    // A new result follows a lookup in the previous cycle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(q_valid && q_ready && !q_entry.is_write))
        else $error("result without a lookup");

    // Unused channels never show up in the flags
    a_unused_channels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.input_bits & ~CHAN_MASK) == 8'h0)
        else $error("flag set on an unused channel");

endmodule

/* test/hcl_result_checker.sv */
// Scoreboard for the hysteresis comparator bank: follows APB register writes,
// predicts each sample set's result and checks every result transaction.
// Depends on hcl_pkg.
module hcl_result_checker
    import hcl_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    input  logic              pready,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_t               s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_t              m_data,
    output int                mismatches,
    output int                pending,
    output int                results_seen
);

    localparam int REPORT_LIMIT = 50;

    cfg_t       regs;
    logic [7:0] trigger_flags;
    logic [7:0] truth_image [256];
    out_t       expected_results [$];
    out_t       want;

    // Channel level from a packed byte register, clamped to the ceiling
    function automatic logic [7:0] level_at(input logic [63:0] levels, input int ch);
        logic [7:0] v;
        v = levels[8*ch +: 8];
        return (v > LEVEL_MAX) ? {1'b0, LEVEL_MAX} : v;
    endfunction

    // Next trigger state of one channel
    function automatic logic next_state(input int ch, input logic [7:0] sample,
                                        input logic on);
        logic [7:0] th;
        logic [7:0] hy;
        logic [8:0] limit;
        th = level_at(regs.threshold, ch);
        hy = level_at(regs.hysteresis, ch);
        if (!regs.invert[ch]) begin
            limit = (hy > th) ? 9'd0 : {1'b0, th - hy};
            if (!on && sample >= th) return 1'b1;
            if (on && {1'b0, sample} < limit) return 1'b0;
        end else begin
            limit = {1'b0, th} + {1'b0, hy};
            if (limit > LEVEL_MAX) limit = {2'b00, LEVEL_MAX};
            if (!on && sample <= th) return 1'b1;
            if (on && {1'b0, sample} > limit) return 1'b0;
        end
        return on;
    endfunction

    // Advance all channels on one sample set and look up the table entry
    function automatic out_t predict_sample_set(input in_t item);
        logic [7:0] lane [8];
        logic [7:0] bit_mask;
        out_t       res;
        lane = '{item.sample_a, item.sample_b, item.sample_c, item.sample_d,
                 item.sample_e, item.sample_f, item.sample_g, item.sample_h};
        for (int ch = 0; ch < CHANNELS && ch < 8; ch++) begin
            bit_mask = 8'h80 >> ch;
            if (next_state(ch, lane[ch], (trigger_flags & bit_mask) != 8'h00))
                trigger_flags = trigger_flags | bit_mask;
            else
                trigger_flags = trigger_flags & ~bit_mask;
        end
        res.input_bits  = trigger_flags;
        res.output_bits = truth_image[trigger_flags];
        return res;
    endfunction

    task automatic report_field(input string field, input logic [7:0] exp_v,
                                input logic [7:0] got_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s expected %02h, got %02h", $time, field, exp_v, got_v);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.threshold  = 64'h3232_3232_3232_3232;
            regs.hysteresis = 64'h0;
            regs.invert     = 8'h00;
            trigger_flags   = 8'h00;
            expected_results.delete();
            mismatches      = 0;
            results_seen    = 0;
        end else begin
            // Check the result transaction against the oldest expectation
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, got %02h/%02h",
                                 $time, m_data.input_bits, m_data.output_bits);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.input_bits !== want.input_bits)
                        report_field("input_bits", want.input_bits, m_data.input_bits);
                    if (m_data.output_bits !== want.output_bits)
                        report_field("output_bits", want.output_bits, m_data.output_bits);
                end
            end

            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:3])
                    REG_THRESHOLD:  regs.threshold  = pwdata;
                    REG_HYSTERESIS: regs.hysteresis = pwdata;
                    REG_INVERT:     regs.invert     = pwdata[7:0];
                    default: ;
                endcase
            end

            // Predict from the accepted input transaction
            if (s_valid && s_ready) begin
                if (s_data.command == CMD_TABLE_WRITE)
                    truth_image[s_data.table_index] = s_data.table_data;
                else
                    expected_results.push_back(predict_sample_set(s_data));
            end
        end
        pending = expected_results.size();
    end

endmodule

/* test/hysteresis_comparator_lut_core_test.sv */
// Testbench top for hysteresis_comparator_lut_core: drives sample sets, table
// writes and APB register settings, and gives the verdict.
// Depends on hcl_pkg, hcl_result_checker and the block under test.
module hysteresis_comparator_lut_core_test;
    import hcl_pkg::*;

    localparam int          PHASES          = 8;
    localparam int          ITEMS_PER_PHASE = 104;
    localparam int          SETTLE_CYCLES   = 6;
    localparam int          STALL_LIMIT     = 2000;
    localparam logic [1:0]  REG_UNUSED      = 2'd3;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [63:0]       pwdata  = '0;
    logic [63:0]       prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_t               s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_t              m_data;

    int mismatches;
    int pending;
    int results_seen;
    int idle_cycles = 0;
    int n_sample_sets = 0;
    int n_table_writes = 0;
    int n_settings = 0;
    bit steady_run = 1'b0;

    // Register values last written, used to aim samples at the switching points
    logic [63:0] set_threshold  = 64'h3232_3232_3232_3232;
    logic [63:0] set_hysteresis = 64'h0;
    logic [7:0]  set_invert     = 8'h00;

    hysteresis_comparator_lut_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hcl_result_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always #2 aclk = ~aclk;

    // Stall the result channel at random, except during the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady_run || ($urandom_range(0, 99) >= 25);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("hysteresis_comparator_lut_core_test failed");
                $finish;
            end
        end
    end

    // Offer one input transaction and hold it until accepted
    task automatic send_item(input in_t item);
        while (!steady_run && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (item.command == CMD_TABLE_WRITE)
            n_table_writes++;
        else
            n_sample_sets++;
    endtask

    // Hold off until every expected result has arrived, then let the pipe drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Eight level bytes, mixing in the clamp edges and out-of-range values
    function automatic logic [63:0] pick_levels(input int span);
        logic [63:0] v;
        int          roll;
        for (int b = 0; b < 8; b++) begin
            roll = $urandom_range(0, 9);
            case (roll)
                0:       v[8*b +: 8] = 8'd0;
                1:       v[8*b +: 8] = 8'd100;
                2:       v[8*b +: 8] = 8'd101;
                3:       v[8*b +: 8] = 8'hFF;
                default: v[8*b +: 8] = 8'($urandom_range(0, span));
            endcase
        end
        return v;
    endfunction

    task automatic program_phase(input int p);
        case (p)
            1: begin
                set_threshold  = 64'h0;
                set_hysteresis = 64'hFFFF_FFFF_FFFF_FFFF;
                set_invert     = 8'hFF;
            end
            2: begin
                set_threshold  = 64'hFFFF_FFFF_FFFF_FFFF;
                set_hysteresis = 64'h0;
                set_invert     = 8'h00;
            end
            4: begin
                set_threshold  = 64'h6464_6464_6464_6464;
                set_hysteresis = pick_levels(100);
                set_invert     = 8'hAA;
            end
            default: begin
                set_threshold  = pick_levels(100);
                set_hysteresis = pick_levels(30);
                set_invert     = 8'($urandom_range(0, 255));
            end
        endcase
        apb_write(REG_THRESHOLD, set_threshold);
        apb_write(REG_HYSTERESIS, set_hysteresis);
        apb_write(REG_INVERT, {$urandom, 24'($urandom_range(0, 16777215)), set_invert});
        // Address past the last register must leave everything alone
        if (p == 1)
            apb_write(REG_UNUSED, {$urandom, $urandom});
        n_settings++;
    endtask

    // Sample for one channel, mostly around its threshold and hysteresis band
    function automatic logic [7:0] aim_sample(input int ch);
        int th;
        int hy;
        int pick;
        int v;
        th = int'(set_threshold[8*ch +: 8]);
        hy = int'(set_hysteresis[8*ch +: 8]);
        if (th > 100) th = 100;
        if (hy > 100) hy = 100;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            v = int'($urandom_range(0, 2*hy + 8));
            v = th + v - hy - 4;
        end else if (pick < 85) begin
            v = $urandom_range(0, 100);
        end else if (pick < 95) begin
            v = $urandom_range(0, 255);
        end else begin
            v = (pick < 97) ? 0 : 255;
        end
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic in_t random_item();
        logic [63:0] lanes;
        logic        cmd;
        for (int ch = 0; ch < 8; ch++)
            lanes[63 - 8*ch -: 8] = aim_sample(ch);
        cmd = ($urandom_range(0, 99) < 12) ? CMD_TABLE_WRITE : CMD_SAMPLE;
        return {cmd, lanes, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole truth table so that no lookup hits an unwritten entry
        for (int i = 0; i < 256; i++)
            send_item({CMD_TABLE_WRITE, {$urandom, $urandom}, 8'(i),
                       8'($urandom_range(0, 255))});

        // Directed: reset settings, threshold 50 with no hysteresis
        send_item({CMD_SAMPLE, 64'h0000_0000_0000_0000, 8'h00, 8'h00});
        send_item({CMD_SAMPLE, 64'h3232_3232_3232_3232, 8'h00, 8'h00});
        send_item({CMD_SAMPLE, 64'h3131_3131_3131_3131, 8'h00, 8'h00});
        send_item({CMD_SAMPLE, 64'h6464_6464_6464_6464, 8'h00, 8'h00});
        send_item({CMD_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h00});
        // Table write with samples that would clear every channel
        send_item({CMD_TABLE_WRITE, 64'h0000_0000_0000_0000, 8'hFF, 8'h00});
        send_item({CMD_SAMPLE, 64'h3232_3232_3232_3232, 8'h00, 8'h00});
        send_item({CMD_TABLE_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'hFF});
        send_item({CMD_SAMPLE, 64'h0000_0000_0000_0000, 8'h00, 8'h00});
        send_item({CMD_SAMPLE, 64'hFF00_FF00_FF00_FF00, 8'h00, 8'h00});
        send_item({CMD_SAMPLE, 64'h00FF_00FF_00FF_00FF, 8'h00, 8'h00});
        // Table fields on a sample set are ignored
        send_item({CMD_SAMPLE, 64'h0000_0000_0000_0000, 8'hFF, 8'hFF});
        send_item({CMD_SAMPLE, 64'h3200_0000_0000_0000, 8'hA5, 8'h5A});
        send_item({CMD_SAMPLE, 64'h0000_0000_0000_0032, 8'h5A, 8'hA5});
        send_item({CMD_TABLE_WRITE, 64'h1234_5678_9ABC_DEF0, 8'h01, 8'h80});
        send_item({CMD_SAMPLE, 64'h0000_0000_0000_0032, 8'h00, 8'h00});

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                wait_idle();
                program_phase(p);
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                steady_run = (p * ITEMS_PER_PHASE + k >= 400) &&
                             (p * ITEMS_PER_PHASE + k < 650);
                send_item(random_item());
            end
        end
        steady_run = 1'b0;

        // Drain and give the verdict
        wait_idle();
        @(negedge aclk);
        $display("Covered %0d sample sets and %0d table writes over %0d register settings,",
                 n_sample_sets, n_table_writes, n_settings + 1);
        $display("with %0d results compared.", results_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("hysteresis_comparator_lut_core_test passed");
        end else begin
            $display("hysteresis_comparator_lut_core_test failed");
        end
        $finish;
    end

endmodule
